@@ hdl/sipclf_pkg.sv @@
package sipclf_pkg;

	localparam int LENGTH_BITS_DEFAULT = 24;

	localparam logic [3:0] KEY_LEN = 4'd15;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_NO_LENGTH  = 2'd1;
	localparam logic [1:0] STATUS_BAD_LENGTH = 2'd2;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       header_end;
		logic       message_last;
		logic [1:0] frame_status;
	} result_t;

	// "Content-Length:"
	function automatic logic [7:0] key_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = "C";
			4'd1:    c = "o";
			4'd2:    c = "n";
			4'd3:    c = "t";
			4'd4:    c = "e";
			4'd5:    c = "n";
			4'd6:    c = "t";
			4'd7:    c = "-";
			4'd8:    c = "L";
			4'd9:    c = "e";
			4'd10:   c = "n";
			4'd11:   c = "g";
			4'd12:   c = "t";
			4'd13:   c = "h";
			4'd14:   c = ":";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

@@ hdl/sipclf_in_if.sv @@
interface sipclf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

@@ hdl/sipclf_out_if.sv @@
interface sipclf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       header_end;
	logic       message_last;
	logic [1:0] frame_status;

	modport source (output valid, output out_byte, output header_end, output message_last,
		output frame_status, input ready);
	modport sink (input valid, input out_byte, input header_end, input message_last,
		input frame_status, output ready);
endinterface

@@ hdl/sipclf_core.sv @@
module sipclf_core #(
	parameter int LENGTH_BITS = sipclf_pkg::LENGTH_BITS_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [7:0]          byte_in,
	output sipclf_pkg::result_t result
);

	typedef enum logic [1:0] {
		VP_SKIP    = 2'd0,
		VP_DIGITS  = 2'd1,
		VP_DONE    = 2'd2,
		VP_SKIP_CR = 2'd3
	} value_phase_t;

	localparam logic [1:0] EM_NONE = 2'd0;
	localparam logic [1:0] EM_LF   = 2'd1;
	localparam logic [1:0] EM_LFCR = 2'd2;

	logic                   in_body_q, in_body_n;
	logic [1:0]             end_match_q, end_match_n;
	logic [3:0]             key_match_q, key_match_n;
	logic                   key_found_q, key_found_n;
	value_phase_t           value_phase_q, value_phase_n;
	logic                   value_neg_q, value_neg_n;
	logic                   value_err_q, value_err_n;
	logic [LENGTH_BITS-1:0] body_length_q, body_length_n;
	logic [LENGTH_BITS-1:0] body_rem_q, body_rem_n;

	always_comb begin
		logic                   clear_all;
		logic                   is_digit;
		logic                   is_space;
		logic [3:0]             digit;
		logic [LENGTH_BITS+3:0] prod;
		logic [LENGTH_BITS-1:0] rem_dec;
		value_phase_t           ph;

		in_body_n     = in_body_q;
		end_match_n   = end_match_q;
		key_match_n   = key_match_q;
		key_found_n   = key_found_q;
		value_phase_n = value_phase_q;
		value_neg_n   = value_neg_q;
		value_err_n   = value_err_q;
		body_length_n = body_length_q;
		body_rem_n    = body_rem_q;
		clear_all     = 1'b0;

		result.out_byte     = byte_in;
		result.header_end   = 1'b0;
		result.message_last = 1'b0;
		result.frame_status = sipclf_pkg::STATUS_OK;

		is_digit = (byte_in >= sipclf_pkg::CH_ZERO) && (byte_in <= sipclf_pkg::CH_NINE);
		is_space = (byte_in == sipclf_pkg::CH_SPACE) ||
			((byte_in >= sipclf_pkg::CH_TAB) && (byte_in <= sipclf_pkg::CH_CR));
		digit = 4'(byte_in - sipclf_pkg::CH_ZERO);
		prod  = ({4'd0, body_length_q} << 3) + ({4'd0, body_length_q} << 1) +
			{{LENGTH_BITS{1'b0}}, digit};
		rem_dec = body_rem_q - 1'b1;
		ph = value_phase_q;

		if (in_body_q) begin
			body_rem_n = rem_dec;
			if (rem_dec == '0) begin
				result.message_last = 1'b1;
				clear_all = 1'b1;
			end
		end else begin
			if (key_found_q) begin
				if (ph == VP_SKIP_CR) begin
					if (byte_in == sipclf_pkg::CH_LF) begin
						ph = VP_DONE;
						value_phase_n = VP_DONE;
					end else begin
						ph = VP_SKIP;
						value_phase_n = VP_SKIP;
					end
				end
				case (ph)
					VP_SKIP: begin
						if (byte_in == sipclf_pkg::CH_CR) begin
							value_phase_n = VP_SKIP_CR;
						end else if (is_space) begin
							value_phase_n = VP_SKIP;
						end else if (byte_in == sipclf_pkg::CH_PLUS ||
							byte_in == sipclf_pkg::CH_MINUS) begin
							value_neg_n = (byte_in == sipclf_pkg::CH_MINUS);
							value_phase_n = VP_DIGITS;
						end else if (is_digit) begin
							value_phase_n = VP_DIGITS;
							body_length_n = {{(LENGTH_BITS-4){1'b0}}, digit};
						end else begin
							value_phase_n = VP_DONE;
						end
					end
					VP_DIGITS: begin
						if (is_digit) begin
							if (value_neg_q) begin
								if (digit != 4'd0) value_err_n = 1'b1;
							end else if (!value_err_q) begin
								if (prod[LENGTH_BITS+3:LENGTH_BITS] != 4'd0)
									value_err_n = 1'b1;
								else
									body_length_n = prod[LENGTH_BITS-1:0];
							end
						end else begin
							value_phase_n = VP_DONE;
						end
					end
					default: ;
				endcase
			end else begin
				if (byte_in == sipclf_pkg::key_char(key_match_q))
					key_match_n = key_match_q + 1'b1;
				else if (byte_in == sipclf_pkg::key_char(4'd0))
					key_match_n = 4'd1;
				else
					key_match_n = 4'd0;
				if (key_match_n >= sipclf_pkg::KEY_LEN) begin
					key_found_n = 1'b1;
					key_match_n = 4'd0;
				end
			end

			if (byte_in == sipclf_pkg::CH_LF) begin
				result.header_end = (end_match_q == EM_LFCR);
				end_match_n = EM_LF;
			end else if (byte_in == sipclf_pkg::CH_CR && end_match_q == EM_LF) begin
				end_match_n = EM_LFCR;
			end else begin
				end_match_n = EM_NONE;
			end

			if (result.header_end) begin
				if (!key_found_n) begin
					result.message_last = 1'b1;
					result.frame_status = sipclf_pkg::STATUS_NO_LENGTH;
					clear_all = 1'b1;
				end else if (value_err_n) begin
					result.message_last = 1'b1;
					result.frame_status = sipclf_pkg::STATUS_BAD_LENGTH;
					clear_all = 1'b1;
				end else if (body_length_n == '0) begin
					result.message_last = 1'b1;
					clear_all = 1'b1;
				end else begin
					in_body_n = 1'b1;
					body_rem_n = body_length_n;
					end_match_n = EM_NONE;
				end
			end
		end

		if (clear_all) begin
			in_body_n     = 1'b0;
			end_match_n   = EM_NONE;
			key_match_n   = 4'd0;
			key_found_n   = 1'b0;
			value_phase_n = VP_SKIP;
			value_neg_n   = 1'b0;
			value_err_n   = 1'b0;
			body_length_n = '0;
			body_rem_n    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_body_q     <= 1'b0;
			end_match_q   <= EM_NONE;
			key_match_q   <= 4'd0;
			key_found_q   <= 1'b0;
			value_phase_q <= VP_SKIP;
			value_neg_q   <= 1'b0;
			value_err_q   <= 1'b0;
			body_length_q <= '0;
			body_rem_q    <= '0;
		end else if (advance) begin
			in_body_q     <= in_body_n;
			end_match_q   <= end_match_n;
			key_match_q   <= key_match_n;
			key_found_q   <= key_found_n;
			value_phase_q <= value_phase_n;
			value_neg_q   <= value_neg_n;
			value_err_q   <= value_err_n;
			body_length_q <= body_length_n;
			body_rem_q    <= body_rem_n;
		end
	end

	ap_body_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		in_body_q |-> body_rem_q != '0)
		else $error("body counter zero while in body");

	ap_key_progress: assert property (@(posedge clk) disable iff (!arst_n)
		key_match_q < sipclf_pkg::KEY_LEN)
		else $error("key match progress out of range");

	ap_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && result.message_last |=> !in_body_q && !key_found_q)
		else $error("state not cleared after last byte");

endmodule

@@ hdl/sip_content_length_framer_unit.sv @@
// SIP framer by Content-Length.
// din carries raw stream bytes (data_byte); dout carries every byte back out
// with header_end, message_last and frame_status. A request moves on a
// channel at a rising edge with valid and ready both high.
// Each byte goes into an input register, is parsed there against the message
// state, and lands in the output register, from which dout offers it.
// Throughput is one byte per clock while dout takes its requests, with the
// parser state updated once per byte (length times ten plus digit).
// The input register is refilled in the same cycle that it drains, and the
// output register reloads in the cycle that dout takes its request.
// When dout stalls, the output register holds its byte, the input register
// holds one more, and din.ready drops until dout takes the waiting request.
// frame_status is 0 except on message_last: 1 no length key, 2 length
// negative or too large; such messages end on the header's final LF.
// Reset (arst_n low) empties both registers and returns the parser to the
// start of a message header.
module sip_content_length_framer_unit #(
	parameter int LENGTH_BITS = sipclf_pkg::LENGTH_BITS_DEFAULT
) (
	input logic          clk,
	input logic          arst_n,
	sipclf_in_if.sink    din,
	sipclf_out_if.source dout
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                advance;
	sipclf_pkg::result_t result_d;
	sipclf_pkg::result_t result_q;
	logic                out_valid_q;

	assign advance   = valid_s1 && (!out_valid_q || dout.ready);
	assign din.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.valid && din.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			byte_s1 <= din.data_byte;
		end
	end

	sipclf_core #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_in (byte_s1),
		.result  (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign dout.valid        = out_valid_q;
	assign dout.out_byte     = result_q.out_byte;
	assign dout.header_end   = result_q.header_end;
	assign dout.message_last = result_q.message_last;
	assign dout.frame_status = result_q.frame_status;

	ap_status_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.frame_status != sipclf_pkg::STATUS_OK
		|-> result_q.message_last && result_q.header_end)
		else $error("error status without header end and last");

	ap_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("stalled input register lost its byte");

	ap_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> din.ready)
		else $error("empty input register not ready");

	ap_out_passthru: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q && result_q.out_byte == $past(byte_s1))
		else $error("output byte differs from input byte");

endmodule

@@ tb/sip_content_length_framer_unit_tb.sv @@
`timescale 1ns / 100ps

module sip_content_length_framer_unit_tb;

	localparam int CLK_PERIOD = 10;
	localparam int LB = sipclf_pkg::LENGTH_BITS_DEFAULT;
	localparam int RANDOM_ITEMS = 900;
	localparam int STALL_LIMIT = 2000;
	localparam int BURST_FIRST = 300;
	localparam int BURST_LAST = 450;
	localparam int DRAIN_AT = 600;
	localparam logic [8*15-1:0] KEY_STR = "Content-Length:";

	typedef enum logic [1:0] {
		VAL_SKIP    = 2'd0,
		VAL_DIGITS  = 2'd1,
		VAL_DONE    = 2'd2,
		VAL_SKIP_CR = 2'd3
	} value_phase_t;

	typedef struct {
		logic [7:0]          b;
		bit                  fixed;
		sipclf_pkg::result_t res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sipclf_in_if  din ();
	sipclf_out_if dout ();

	sip_content_length_framer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.dout   (dout)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// framer state
	logic          p_in_body;
	logic [1:0]    p_end_prog;
	logic [3:0]    p_key_prog;
	logic          p_key_found;
	value_phase_t  p_phase;
	logic          p_neg;
	logic          p_err;
	logic [LB-1:0] p_len;
	logic [LB-1:0] p_rem;

	stim_row_t           stream[$];
	sipclf_pkg::result_t framed_bytes_due[$];
	int                  fail_count = 0;
	int                  result_count = 0;
	int                  stall_cycles = 0;
	bit                  no_idle = 1'b0;
	sipclf_pkg::result_t got;
	sipclf_pkg::result_t want;

	task automatic restart_message();
		p_in_body = 1'b0;
		p_end_prog = 2'd0;
		p_key_prog = 4'd0;
		p_key_found = 1'b0;
		p_phase = VAL_SKIP;
		p_neg = 1'b0;
		p_err = 1'b0;
		p_len = '0;
		p_rem = '0;
	endtask

	function automatic bit is_digit(input logic [7:0] c);
		return c >= sipclf_pkg::CH_ZERO && c <= sipclf_pkg::CH_NINE;
	endfunction

	task automatic parse_length_char(input logic [7:0] c);
		logic [LB+3:0] acc;
		if (p_phase == VAL_SKIP_CR && c == sipclf_pkg::CH_LF) begin
			p_phase = VAL_DONE;
		end else begin
			if (p_phase == VAL_SKIP_CR)
				p_phase = VAL_SKIP;
			case (p_phase)
				VAL_SKIP: begin
					if (c == sipclf_pkg::CH_CR) begin
						p_phase = VAL_SKIP_CR;
					end else if (c == sipclf_pkg::CH_SPACE ||
						(c >= sipclf_pkg::CH_TAB && c <= sipclf_pkg::CH_CR)) begin
					end else if (c == sipclf_pkg::CH_PLUS || c == sipclf_pkg::CH_MINUS) begin
						p_neg = (c == sipclf_pkg::CH_MINUS);
						p_phase = VAL_DIGITS;
					end else if (is_digit(c)) begin
						p_phase = VAL_DIGITS;
						p_len = LB'(c - sipclf_pkg::CH_ZERO);
					end else begin
						p_phase = VAL_DONE;
					end
				end
				VAL_DIGITS: begin
					if (!is_digit(c)) begin
						p_phase = VAL_DONE;
					end else if (p_neg) begin
						if (c != sipclf_pkg::CH_ZERO)
							p_err = 1'b1;
					end else if (!p_err) begin
						acc = {4'd0, p_len} * 10 + (LB + 4)'(c - sipclf_pkg::CH_ZERO);
						if (acc > {4'd0, {LB{1'b1}}})
							p_err = 1'b1;
						else
							p_len = acc[LB-1:0];
					end
				end
				default: ;
			endcase
		end
	endtask

	task automatic frame_byte(input logic [7:0] c, output sipclf_pkg::result_t r);
		r.out_byte = c;
		r.header_end = 1'b0;
		r.message_last = 1'b0;
		r.frame_status = sipclf_pkg::STATUS_OK;
		if (p_in_body) begin
			p_rem = p_rem - 1'b1;
			if (p_rem == '0) begin
				r.message_last = 1'b1;
				restart_message();
			end
		end else begin
			if (p_key_found) begin
				parse_length_char(c);
			end else begin
				if (c == KEY_STR[8*(14 - p_key_prog) +: 8])
					p_key_prog = p_key_prog + 1'b1;
				else
					p_key_prog = (c == KEY_STR[8*14 +: 8]) ? 4'd1 : 4'd0;
				if (p_key_prog >= sipclf_pkg::KEY_LEN) begin
					p_key_found = 1'b1;
					p_key_prog = 4'd0;
				end
			end

			if (c == sipclf_pkg::CH_LF) begin
				if (p_end_prog == 2'd2)
					r.header_end = 1'b1;
				p_end_prog = 2'd1;
			end else if (c == sipclf_pkg::CH_CR && p_end_prog == 2'd1) begin
				p_end_prog = 2'd2;
			end else begin
				p_end_prog = 2'd0;
			end

			if (r.header_end) begin
				if (!p_key_found) begin
					r.message_last = 1'b1;
					r.frame_status = sipclf_pkg::STATUS_NO_LENGTH;
					restart_message();
				end else if (p_err) begin
					r.message_last = 1'b1;
					r.frame_status = sipclf_pkg::STATUS_BAD_LENGTH;
					restart_message();
				end else if (p_len == '0) begin
					r.message_last = 1'b1;
					restart_message();
				end else begin
					p_in_body = 1'b1;
					p_rem = p_len;
					p_end_prog = 2'd0;
				end
			end
		end
	endtask

	task automatic add_row(input logic [7:0] b, input bit fixed, input logic hdr,
		input logic last, input logic [1:0] st);
		stim_row_t row;
		row.b = b;
		row.fixed = fixed;
		row.res = {b, hdr, last, st};
		stream.push_back(row);
	endtask

	task automatic push_byte(input logic [7:0] b);
		add_row(b, 1'b0, 1'b0, 1'b0, sipclf_pkg::STATUS_OK);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	task automatic push_eol();
		push_byte(sipclf_pkg::CH_CR);
		push_byte(sipclf_pkg::CH_LF);
	endtask

	task automatic push_blank();
		case ($urandom_range(4))
			0: push_byte(sipclf_pkg::CH_SPACE);
			1: push_byte(sipclf_pkg::CH_TAB);
			2: push_byte(8'h0B);
			3: push_byte(8'h0C);
			default: push_byte(sipclf_pkg::CH_CR);
		endcase
	endtask

	// Mostly well-formed messages with random content, some noise and broken keys.
	task automatic build_message();
		int unsigned kind;
		int unsigned n;
		int unsigned body_len;
		string val;
		kind = $urandom_range(99);
		body_len = 0;
		if (kind < 10) begin
			n = $urandom_range(24, 1);
			repeat (n) push_byte(8'($urandom_range(255)));
		end else begin
			if ($urandom_range(1)) begin
				n = $urandom_range(8);
				repeat (n) push_byte(8'($urandom_range(8'h7E, 8'h21)));
				push_eol();
			end
			if (kind < 18) begin
				val = "Content-Length:";
				push_text(val.substr(0, $urandom_range(13)));
				push_text("x");
				push_eol();
			end
			if (kind < 26) begin
				if ($urandom_range(1)) begin
					push_text("content-length: 3");
					push_eol();
				end
			end else begin
				push_text("Content-Length:");
				n = $urandom_range(2);
				repeat (n) push_blank();
				case ($urandom_range(15))
					0: val = "";
					1: val = "-0";
					2: val = "-";
					3: val = $sformatf("-%0d", $urandom_range(99, 1));
					4: val = "16777216";
					5: val = "99999999999999";
					6: begin
						body_len = $urandom_range(40, 1);
						val = $sformatf("+%0d", body_len);
					end
					7: begin
						body_len = $urandom_range(40, 1);
						val = $sformatf("00000000%0d", body_len);
					end
					8: val = "0";
					9: begin
						body_len = $urandom_range(300, 100);
						val = $sformatf("%0d", body_len);
					end
					default: begin
						body_len = $urandom_range(40, 1);
						val = $sformatf("%0d", body_len);
					end
				endcase
				push_text(val);
				if ($urandom_range(1))
					push_text(" ;x");
				push_eol();
				if ($urandom_range(2) == 0) begin
					push_text("Content-Length: 9");
					push_eol();
				end
			end
			push_eol();
			repeat (body_len) push_byte(8'($urandom_range(255)));
		end
	endtask

	task automatic send_byte(input stim_row_t row, input bit drain_first);
		sipclf_pkg::result_t r;
		@(negedge clk);
		if (drain_first) begin
			din.valid <= 1'b0;
			do @(negedge clk); while (framed_bytes_due.size() != 0);
		end
		while (!no_idle && $urandom_range(99) < 38) begin
			din.valid <= 1'b0;
			@(negedge clk);
		end
		din.valid <= 1'b1;
		din.data_byte <= row.b;
		do @(posedge clk); while (!din.ready);
		frame_byte(row.b, r);
		framed_bytes_due.push_back(row.fixed ? row.res : r);
	endtask

	always @(negedge clk)
		dout.ready <= no_idle || ($urandom_range(99) >= 38);

	always @(posedge clk) begin
		if (arst_n && dout.valid && dout.ready) begin
			got = {dout.out_byte, dout.header_end, dout.message_last, dout.frame_status};
			if (framed_bytes_due.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result %0d: byte %02h hdr %b last %b status %0d",
						result_count, got.out_byte, got.header_end, got.message_last,
						got.frame_status);
			end else begin
				want = framed_bytes_due.pop_front();
				if (got.out_byte !== want.out_byte || got.header_end !== want.header_end ||
					got.message_last !== want.message_last ||
					got.frame_status !== want.frame_status) begin
					fail_count++;
					if (fail_count <= 10)
						$display("result %0d: expected %02h/%b/%b/%0d, got %02h/%b/%b/%0d",
							result_count, want.out_byte, want.header_end, want.message_last,
							want.frame_status, got.out_byte, got.header_end, got.message_last,
							got.frame_status);
				end
			end
			result_count++;
		end
	end

	always @(posedge clk) begin
		if ((din.valid && din.ready) || (dout.valid && dout.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		int n_directed;
		din.valid = 1'b0;
		din.data_byte = 8'h00;
		restart_message();

		// no key right after reset
		add_row(sipclf_pkg::CH_LF, 1'b1, 1'b0, 1'b0, sipclf_pkg::STATUS_OK);
		add_row(sipclf_pkg::CH_CR, 1'b1, 1'b0, 1'b0, sipclf_pkg::STATUS_OK);
		add_row(sipclf_pkg::CH_LF, 1'b1, 1'b1, 1'b1, sipclf_pkg::STATUS_NO_LENGTH);
		// byte extremes in a header without key
		add_row(8'h00, 1'b1, 1'b0, 1'b0, sipclf_pkg::STATUS_OK);
		add_row(8'hFF, 1'b1, 1'b0, 1'b0, sipclf_pkg::STATUS_OK);
		push_byte(sipclf_pkg::CH_LF);
		push_byte(sipclf_pkg::CH_CR);
		add_row(sipclf_pkg::CH_LF, 1'b1, 1'b1, 1'b1, sipclf_pkg::STATUS_NO_LENGTH);
		// negative length
		push_text("Content-Length:-1");
		push_eol();
		push_byte(sipclf_pkg::CH_CR);
		add_row(sipclf_pkg::CH_LF, 1'b1, 1'b1, 1'b1, sipclf_pkg::STATUS_BAD_LENGTH);
		n_directed = stream.size();

		while (stream.size() < n_directed + RANDOM_ITEMS)
			build_message();

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < stream.size(); i++) begin
			no_idle = (i >= BURST_FIRST && i < BURST_LAST);
			send_byte(stream[i], i == DRAIN_AT);
		end
		@(negedge clk);
		din.valid <= 1'b0;
		no_idle = 1'b0;

		while (framed_bytes_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (fail_count == 0 && framed_bytes_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
